### src/tdpa_pkg.sv
// shared types and command codes for the thumb data-processing alu
`timescale 1ns / 1ps
package tdpa_pkg;

    localparam int REG_COUNT = 8;
    localparam int CMD_W  = 5;
    localparam int IMM_W  = 8;
    localparam int REG_W  = $clog2(REG_COUNT);
    localparam int DATA_W = 32;

    // shift by immediate
    localparam logic [CMD_W-1:0] CMD_LSL_IMM  = 5'd0;
    localparam logic [CMD_W-1:0] CMD_LSR_IMM  = 5'd1;
    localparam logic [CMD_W-1:0] CMD_ASR_IMM  = 5'd2;
    // three-bit add / subtract
    localparam logic [CMD_W-1:0] CMD_ADD_REG  = 5'd3;
    localparam logic [CMD_W-1:0] CMD_SUB_REG  = 5'd4;
    localparam logic [CMD_W-1:0] CMD_ADD_IMM3 = 5'd5;
    localparam logic [CMD_W-1:0] CMD_SUB_IMM3 = 5'd6;
    // 8-bit immediate forms
    localparam logic [CMD_W-1:0] CMD_MOV_IMM8 = 5'd7;
    localparam logic [CMD_W-1:0] CMD_CMP_IMM8 = 5'd8;
    localparam logic [CMD_W-1:0] CMD_ADD_IMM8 = 5'd9;
    localparam logic [CMD_W-1:0] CMD_SUB_IMM8 = 5'd10;
    // register alu operations
    localparam logic [CMD_W-1:0] CMD_AND      = 5'd11;
    localparam logic [CMD_W-1:0] CMD_EOR      = 5'd12;
    localparam logic [CMD_W-1:0] CMD_LSL      = 5'd13;
    localparam logic [CMD_W-1:0] CMD_LSR      = 5'd14;
    localparam logic [CMD_W-1:0] CMD_ASR      = 5'd15;
    localparam logic [CMD_W-1:0] CMD_ADC      = 5'd16;
    localparam logic [CMD_W-1:0] CMD_SBC      = 5'd17;
    localparam logic [CMD_W-1:0] CMD_ROR      = 5'd18;
    localparam logic [CMD_W-1:0] CMD_TST      = 5'd19;
    localparam logic [CMD_W-1:0] CMD_NEG      = 5'd20;
    localparam logic [CMD_W-1:0] CMD_CMP      = 5'd21;
    localparam logic [CMD_W-1:0] CMD_CMN      = 5'd22;
    localparam logic [CMD_W-1:0] CMD_ORR      = 5'd23;
    localparam logic [CMD_W-1:0] CMD_MUL      = 5'd24;
    localparam logic [CMD_W-1:0] CMD_BIC      = 5'd25;
    localparam logic [CMD_W-1:0] CMD_MVN      = 5'd26;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    typedef struct packed {
        logic              we;
        logic [DATA_W-1:0] result;
        t_flags            flags;
    } t_alu_res;

endpackage

### src/tdpa_alu.sv
// combinational execute logic: adder, barrel shifter, logic ops, multiplier, flags
`timescale 1ns / 1ps
module tdpa_alu (
    input  logic [tdpa_pkg::CMD_W-1:0]  i_command,
    input  logic [tdpa_pkg::DATA_W-1:0] i_op_a,
    input  logic [tdpa_pkg::DATA_W-1:0] i_op_b,
    input  logic [tdpa_pkg::IMM_W-1:0]  i_immediate,
    input  tdpa_pkg::t_flags            i_flags,
    output tdpa_pkg::t_alu_res          o_res
);
    import tdpa_pkg::*;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // returns {carry, result}
    function automatic logic [DATA_W:0] barrel(input logic [1:0] kind,
                                               input logic [DATA_W-1:0] val,
                                               input logic [7:0] amt,
                                               input logic cin);
        logic [DATA_W:0]   t;
        logic [2*DATA_W-1:0] rot;
        logic [DATA_W-1:0] r;
        logic              c;
        r = val;
        c = cin;
        t = '0;
        rot = '0;
        if (amt != 8'd0) begin
            case (kind)
                SH_LSL: begin
                    if (amt < 8'd32) begin
                        t = {1'b0, val} << amt[4:0];
                        r = t[DATA_W-1:0];
                        c = t[DATA_W];
                    end else begin
                        r = '0;
                        c = (amt == 8'd32) ? val[0] : 1'b0;
                    end
                end
                SH_LSR: begin
                    if (amt < 8'd32) begin
                        t = {val, 1'b0} >> amt[4:0];
                        r = t[DATA_W:1];
                        c = t[0];
                    end else begin
                        r = '0;
                        c = (amt == 8'd32) ? val[DATA_W-1] : 1'b0;
                    end
                end
                SH_ASR: begin
                    if (amt < 8'd32) begin
                        t = $unsigned($signed({val, 1'b0}) >>> amt[4:0]);
                        r = t[DATA_W:1];
                        c = t[0];
                    end else begin
                        r = {DATA_W{val[DATA_W-1]}};
                        c = val[DATA_W-1];
                    end
                end
                default: begin
                    rot = {val, val} >> amt[4:0];
                    r = rot[DATA_W-1:0];
                    c = r[DATA_W-1];
                end
            endcase
        end
        return {c, r};
    endfunction

    // returns {carry, overflow, result}
    function automatic logic [DATA_W+1:0] add_cv(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b,
                                                 input logic cin);
        logic [DATA_W:0] sum;
        logic            v;
        sum = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, cin};
        v = ~(a[DATA_W-1] ^ b[DATA_W-1]) & (a[DATA_W-1] ^ sum[DATA_W-1]);
        return {sum[DATA_W], v, sum[DATA_W-1:0]};
    endfunction

    logic [DATA_W-1:0] imm_ext;
    logic [DATA_W-1:0] imm3_ext;
    logic [DATA_W-1:0] op2;
    logic [7:0]        shift_amt;
    logic [DATA_W:0]   sh;
    logic [DATA_W+1:0] ad;
    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] res;
    logic              c;
    logic              v;
    logic              we;
    logic              set_nz;

    assign imm_ext  = {{(DATA_W-IMM_W){1'b0}}, i_immediate};
    assign imm3_ext = {{(DATA_W-3){1'b0}}, i_immediate[2:0]};
    assign op2      = (i_command == CMD_ADD_REG || i_command == CMD_SUB_REG) ? i_op_a : imm3_ext;
    // only the low word of the product is kept
    assign prod     = i_op_a * i_op_b;

    always_comb begin
        res       = '0;
        c         = i_flags.c;
        v         = i_flags.v;
        we        = 1'b1;
        set_nz    = 1'b1;
        sh        = '0;
        ad        = '0;
        shift_amt = {3'b000, i_immediate[4:0]};
        case (i_command)
            CMD_LSL_IMM, CMD_LSR_IMM, CMD_ASR_IMM: begin
                // a zero count on the right shifts means 32
                if (i_command != CMD_LSL_IMM && i_immediate[4:0] == 5'd0) begin
                    shift_amt = 8'd32;
                end
                sh  = barrel(i_command[1:0], i_op_b, shift_amt, i_flags.c);
                res = sh[DATA_W-1:0];
                c   = sh[DATA_W];
            end
            CMD_ADD_REG, CMD_ADD_IMM3: begin
                ad = add_cv(i_op_b, op2, 1'b0);
                {c, v, res} = ad;
            end
            CMD_SUB_REG, CMD_SUB_IMM3: begin
                ad = add_cv(i_op_b, ~op2, 1'b1);
                {c, v, res} = ad;
            end
            CMD_MOV_IMM8: res = imm_ext;
            CMD_CMP_IMM8: begin
                ad = add_cv(i_op_a, ~imm_ext, 1'b1);
                {c, v, res} = ad;
                we = 1'b0;
            end
            CMD_ADD_IMM8: begin
                ad = add_cv(i_op_a, imm_ext, 1'b0);
                {c, v, res} = ad;
            end
            CMD_SUB_IMM8: begin
                ad = add_cv(i_op_a, ~imm_ext, 1'b1);
                {c, v, res} = ad;
            end
            CMD_AND: res = i_op_a & i_op_b;
            CMD_EOR: res = i_op_a ^ i_op_b;
            CMD_LSL, CMD_LSR, CMD_ASR, CMD_ROR: begin
                // register shifts take the low byte of the source
                case (i_command)
                    CMD_LSL: sh = barrel(SH_LSL, i_op_a, i_op_b[7:0], i_flags.c);
                    CMD_LSR: sh = barrel(SH_LSR, i_op_a, i_op_b[7:0], i_flags.c);
                    CMD_ASR: sh = barrel(SH_ASR, i_op_a, i_op_b[7:0], i_flags.c);
                    default: sh = barrel(SH_ROR, i_op_a, i_op_b[7:0], i_flags.c);
                endcase
                res = sh[DATA_W-1:0];
                c   = sh[DATA_W];
            end
            CMD_ADC: begin
                ad = add_cv(i_op_a, i_op_b, i_flags.c);
                {c, v, res} = ad;
            end
            CMD_SBC: begin
                ad = add_cv(i_op_a, ~i_op_b, i_flags.c);
                {c, v, res} = ad;
            end
            CMD_TST: begin
                res = i_op_a & i_op_b;
                we  = 1'b0;
            end
            CMD_NEG: begin
                ad = add_cv('0, ~i_op_b, 1'b1);
                {c, v, res} = ad;
            end
            CMD_CMP: begin
                ad = add_cv(i_op_a, ~i_op_b, 1'b1);
                {c, v, res} = ad;
                we = 1'b0;
            end
            CMD_CMN: begin
                ad = add_cv(i_op_a, i_op_b, 1'b0);
                {c, v, res} = ad;
                we = 1'b0;
            end
            CMD_ORR: res = i_op_a | i_op_b;
            CMD_MUL: res = prod;
            CMD_BIC: res = i_op_a & ~i_op_b;
            CMD_MVN: res = ~i_op_b;
            default: begin
                // unused codes change nothing
                we     = 1'b0;
                set_nz = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_res.we     = we;
        o_res.result = res;
        o_res.flags  = i_flags;
        if (set_nz) begin
            o_res.flags.n = res[DATA_W-1];
            o_res.flags.z = (res == '0);
            o_res.flags.c = c;
            o_res.flags.v = v;
        end
    end

endmodule

### src/thumb_data_processing_alu_core.sv
// top level: input register, register file with forwarding, alu, result register
`timescale 1ns / 1ps
// o_valid rises once an instruction has gone through the execute register into the result
//   register; the result transfer then completes at a clock edge where i_stall is low
// throughput: one instruction per cycle unless stalled; combinational alu (32x32 multiplier)
// operands are read from the register file when the instruction is taken, with the
//   result of the instruction ahead of it forwarded in, so dependent instructions flow
// reset (i_rst_n low, synchronous): both stages empty, all registers and NZCV read as zero
module thumb_data_processing_alu_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // instruction channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [tdpa_pkg::CMD_W-1:0]   i_command,
    input  logic [tdpa_pkg::REG_W-1:0]   i_dest_reg,
    input  logic [tdpa_pkg::REG_W-1:0]   i_src_reg,
    input  logic [tdpa_pkg::REG_W-1:0]   i_second_reg,
    input  logic [tdpa_pkg::IMM_W-1:0]   i_immediate,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_write_enable,
    output logic [tdpa_pkg::REG_W-1:0]   o_write_reg,
    output logic [tdpa_pkg::DATA_W-1:0]  o_result_value,
    output logic                         o_flag_n,
    output logic                         o_flag_z,
    output logic                         o_flag_c,
    output logic                         o_flag_v
);
    import tdpa_pkg::*;

    localparam int IDX_W = $clog2(REG_COUNT);

    // register file: one write port, two registered read ports, per-entry valid bits
    logic [DATA_W-1:0] r_regs [REG_COUNT];
    logic [REG_COUNT-1:0] r_reg_ok;

    // execute stage (operands already read)
    logic              r_in_valid;
    logic [CMD_W-1:0]  r_in_cmd;
    logic [REG_W-1:0]  r_in_dest;
    logic [IMM_W-1:0]  r_in_imm;
    logic [DATA_W-1:0] r_op_a;
    logic [DATA_W-1:0] r_op_b;

    // architectural flags
    t_flags            r_flags;

    // result stage
    logic              r_out_valid;
    logic              r_out_we;
    logic [REG_W-1:0]  r_out_reg;
    logic [DATA_W-1:0] r_out_value;
    t_flags            r_out_flags;

    t_alu_res          alu_res;
    logic              advance;      // execute stage moves into the result register
    logic              in_xfer;
    logic              retire;       // a real instruction leaves the execute stage
    logic [IDX_W-1:0]  addr_a;
    logic [IDX_W-1:0]  addr_b;
    logic [IDX_W-1:0]  wr_addr;
    logic              fwd_a;
    logic              fwd_b;

    // result register frees up when empty or when its transfer completes
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign in_xfer = i_valid && !o_stall;
    assign retire  = r_in_valid && advance;

    // port a reads Rm for register add/subtract and Rd otherwise; port b reads Rs
    assign addr_a  = (i_command inside {CMD_ADD_REG, CMD_SUB_REG}) ?
                     i_second_reg[IDX_W-1:0] : i_dest_reg[IDX_W-1:0];
    assign addr_b  = i_src_reg[IDX_W-1:0];
    assign wr_addr = r_in_dest[IDX_W-1:0];

    // the instruction in execute writes back at the same edge the new one reads
    assign fwd_a = retire && alu_res.we && (wr_addr == addr_a);
    assign fwd_b = retire && alu_res.we && (wr_addr == addr_b);

    tdpa_alu u_alu (
        .i_command   (r_in_cmd),
        .i_op_a      (r_op_a),
        .i_op_b      (r_op_b),
        .i_immediate (r_in_imm),
        .i_flags     (r_flags),
        .o_res       (alu_res)
    );

    // register file storage and read ports
    always_ff @(posedge i_clk) begin
        if (retire && alu_res.we) begin
            r_regs[wr_addr] <= alu_res.result;
        end
        if (in_xfer) begin
            if (fwd_a) begin
                r_op_a <= alu_res.result;
            end else if (r_reg_ok[addr_a]) begin
                r_op_a <= r_regs[addr_a];
            end else begin
                r_op_a <= '0;
            end
            if (fwd_b) begin
                r_op_b <= alu_res.result;
            end else if (r_reg_ok[addr_b]) begin
                r_op_b <= r_regs[addr_b];
            end else begin
                r_op_b <= '0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_ok    <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (retire) begin
                r_flags <= alu_res.flags;
                if (alu_res.we) begin
                    r_reg_ok[wr_addr] <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_cmd  <= i_command;
            r_in_dest <= i_dest_reg;
            r_in_imm  <= i_immediate;
        end
        if (retire) begin
            r_out_we    <= alu_res.we;
            r_out_reg   <= r_in_dest;
            r_out_value <= alu_res.result;
            r_out_flags <= alu_res.flags;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_write_enable = r_out_we;
    assign o_write_reg    = r_out_reg;
    assign o_result_value = r_out_value;
    assign o_flag_n       = r_out_flags.n;
    assign o_flag_z       = r_out_flags.z;
    assign o_flag_c       = r_out_flags.c;
    assign o_flag_v       = r_out_flags.v;

endmodule

### src/tdpa_checker.sv
// port-level checks for the thumb alu core and their bind
`timescale 1ns / 1ps
module tdpa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic                        o_write_enable,
    input logic [tdpa_pkg::REG_W-1:0]  o_write_reg,
    input logic [tdpa_pkg::DATA_W-1:0] o_result_value,
    input logic                        o_flag_n,
    input logic                        o_flag_z,
    input logic                        o_flag_c,
    input logic                        o_flag_v
);
    import tdpa_pkg::*;

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while result side is free");

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_write_enable)
            && $stable(o_write_reg) && $stable(o_result_value) && $stable(o_flag_n)
            && $stable(o_flag_z) && $stable(o_flag_c) && $stable(o_flag_v)))
        else $error("stalled result changed");

    // every written value updated N and Z from itself
    a_nz_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_enable) |->
            (o_flag_n == o_result_value[DATA_W-1] && o_flag_z == (o_result_value == '0)))
        else $error("N/Z do not match written value");

endmodule

bind thumb_data_processing_alu_core tdpa_checker u_tdpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_write_enable (o_write_enable),
    .o_write_reg    (o_write_reg),
    .o_result_value (o_result_value),
    .o_flag_n       (o_flag_n),
    .o_flag_z       (o_flag_z),
    .o_flag_c       (o_flag_c),
    .o_flag_v       (o_flag_v)
);
